// ===== src/base64_stream_encoder_defines.svh =====
// ----------------------------------------------------------------------------
// base64 stream encoder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication
`define B64E_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64e assertion failed");

// next-cycle implication
`define B64E_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64e assertion failed");

`endif

// ===== src/b64e_pkg.sv =====
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the character map of the base64 encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [5:0] SLICE_MASK = 6'h3F;

  // one group request from front to back
  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  nbytes;
    logic        is_last;
  } group_req_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v & SLICE_MASK};
    priority if (w < 8'd26) begin
      c = 8'h41 + w;
    end else if (w < 8'd52) begin
      c = 8'h61 + (w - 8'd26);
    end else if (w < 8'd62) begin
      c = 8'h30 + (w - 8'd52);
    end else if (w == 8'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== src/b64e_byte_if.sv =====
// ----------------------------------------------------------------------------
// b64e_byte_if
// input byte channel: valid/ready with one message byte and end flag
// ----------------------------------------------------------------------------
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== src/b64e_char_if.sv =====
// ----------------------------------------------------------------------------
// b64e_char_if
// output character channel: valid/ready with one character and last flag
// ----------------------------------------------------------------------------
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== src/b64e_queue.sv =====
// ----------------------------------------------------------------------------
// b64e_queue
// short register queue of group requests between front and back
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module b64e_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64e_pkg::group_req_t push_req,
  output logic                 q_ready,
  input  logic                 pop,
  output logic                 q_valid,
  output b64e_pkg::group_req_t pop_req
);

  b64e_pkg::group_req_t                 mem_r [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [b64e_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [b64e_pkg::QCNT_W-1:0]          cnt_r, cnt_nxt;
  logic                                 do_push, do_pop;

  localparam logic [b64e_pkg::QPTR_W-1:0] PTR_LAST = b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1);
  localparam logic [b64e_pkg::QCNT_W-1:0] CNT_FULL = b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH);

  assign q_ready = (cnt_r != CNT_FULL);
  assign q_valid = (cnt_r != '0);
  assign pop_req = mem_r[rd_ptr_r];
  assign do_push = push && q_ready;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req;
    end
  end

  `B64E_ASSERT_NOW(a_no_overflow, push, q_ready)

endmodule

// ===== src/b64e_front.sv =====
// ----------------------------------------------------------------------------
// b64e_front
// takes bytes, collects groups of up to three and queues group requests
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module b64e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  b64e_byte_if.sink            in_bus,
  output logic                 push,
  output b64e_pkg::group_req_t push_req,
  input  logic                 q_ready
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        take;
  logic [15:0] merged;

  assign in_bus.ready = q_ready;
  assign take         = in_bus.valid && q_ready;

  always_comb begin
    merged = (cnt_r == 2'd1) ? {pend_r[15:8], in_bus.data_byte} : {in_bus.data_byte, 8'h00};
    pend_nxt         = pend_r;
    cnt_nxt          = cnt_r;
    push             = 1'b0;
    push_req.group   = {merged, 8'h00};
    push_req.nbytes  = cnt_r + 2'd1;
    push_req.is_last = 1'b1;
    if (cnt_r[1]) begin
      // full group
      push_req.group   = {pend_r, in_bus.data_byte};
      push_req.nbytes  = 2'd3;
      push_req.is_last = in_bus.end_of_message;
      if (take) begin
        push     = 1'b1;
        pend_nxt = '0;
        cnt_nxt  = '0;
      end
    end else if (take) begin
      if (in_bus.end_of_message) begin
        push     = 1'b1;
        pend_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        pend_nxt = merged;
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `B64E_ASSERT_NXT(a_group_clears, take && (cnt_r[1] || in_bus.end_of_message), cnt_r == 2'd0)

endmodule

// ===== src/b64e_back.sv =====
// ----------------------------------------------------------------------------
// b64e_back
// turns each queued group into four characters, one per cycle while out_bus is ready
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_defines.svh"

module b64e_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  b64e_pkg::group_req_t pop_req,
  output logic                 pop,
  b64e_char_if.source          out_bus
);

  logic [23:0] grp_r, grp_nxt;
  logic [1:0]  nbytes_r, nbytes_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        active_r, active_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        last_char_r, last_char_nxt;
  logic        advance;
  logic [5:0]  slice;

  assign advance = active_r && (!out_valid_r || out_bus.ready);
  assign pop     = q_valid && (!active_r || (advance && idx_r == 2'd3));

  always_comb begin
    unique case (idx_r)
      2'd0:    slice = grp_r[23:18];
      2'd1:    slice = grp_r[17:12];
      2'd2:    slice = grp_r[11:6];
      default: slice = grp_r[5:0];
    endcase
  end

  always_comb begin
    grp_nxt       = grp_r;
    nbytes_nxt    = nbytes_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    last_char_nxt = last_char_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = (idx_r > nbytes_r) ? b64e_pkg::PAD_CHAR : b64e_pkg::enc_char(slice);
      last_char_nxt = (idx_r == 2'd3) && last_r;
      idx_nxt       = idx_r + 2'd1;
      if (idx_r == 2'd3) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      grp_nxt    = pop_req.group;
      nbytes_nxt = pop_req.nbytes;
      last_nxt   = pop_req.is_last;
      idx_nxt    = 2'd0;
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r       <= grp_nxt;
    nbytes_r    <= nbytes_nxt;
    last_r      <= last_nxt;
    out_char_r  <= out_char_nxt;
    last_char_r <= last_char_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_char  = out_char_r;
  assign out_bus.last_char = last_char_r;

  `B64E_ASSERT_NXT(a_last_only_fourth, advance && idx_r != 2'd3, !last_char_r)
  `B64E_ASSERT_NOW(a_pop_when_free, pop, !active_r || idx_r == 2'd3)

endmodule

// ===== src/base64_stream_encoder.sv =====
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// Bytes enter on in_bus, one per request, with end_of_message on the last
// byte of a message; characters leave on out_bus, one per request, with
// last_char on the final character. A byte is taken every cycle while the
// two-entry group queue has room; every third byte, or a byte that ends the
// message, queues one group that becomes four characters. The character
// stage emits one character per cycle while out_bus is ready, so the
// character side, not the byte side, limits a steady stream of full groups.
// Once the byte that closes a group is taken, the group passes the queue
// entry and the group register before its first character is registered.
module base64_stream_encoder (
  input  logic        clk,
  input  logic        rst_n,
  b64e_byte_if.sink   in_bus,
  b64e_char_if.source out_bus
);

  logic                 push, q_ready, pop, q_valid;
  b64e_pkg::group_req_t push_req, pop_req;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .push     (push),
    .push_req (push_req),
    .q_ready  (q_ready)
  );

  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .pop_req  (pop_req)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .pop_req  (pop_req),
    .pop      (pop),
    .out_bus  (out_bus)
  );

endmodule
